/* sv/lsra_pkg.sv */
package lsra_pkg;

    // Spill slot sizes in bytes and the saturation point of the spill counter.
    localparam logic [16:0] SLOT_SCALAR     = 17'd8;
    localparam logic [16:0] SLOT_VECTOR     = 17'd16;
    localparam logic [15:0] COUNTER_MAX     = 16'hFFFF;
    localparam logic [5:0]  REG_COUNT_RESET = 6'd32;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_RUN   = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        KIND_REG   = 2'd0,
        KIND_SPILL = 2'd1,
        KIND_MARK  = 2'd2
    } t_kind;

    typedef enum logic {
        CFG_REG_COUNT   = 1'b0,
        CFG_VECTOR_MODE = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPIRE,
        S_DECIDE,
        S_INSERT
    } t_state;

    typedef struct packed {
        t_func       func;
        logic [31:0] value_name;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
    } t_req;

    typedef struct packed {
        logic [31:0] report_name;
        t_kind       kind;
        logic [4:0]  register_index;
        logic [15:0] spill_offset;
        logic        last;
    } t_res;

    typedef struct packed {
        t_cfg_index  index;
        logic [5:0]  data;
    } t_cfg;

    // Controls broadcast to every cell of the active list.
    typedef struct packed {
        logic clear;
        logic shift;
        logic drop_tail;
        logic insert;
    } t_active_ctl;

    // Controls broadcast to every cell of the free stack.
    typedef struct packed {
        logic load;
        logic push;
        logic pop;
    } t_free_ctl;

endpackage

/* sv/lsra_req_if.sv */
interface lsra_req_if;
    logic          valid;
    logic          ready;
    lsra_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/lsra_res_if.sv */
interface lsra_res_if;
    logic          valid;
    logic          ready;
    lsra_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/lsra_cfg_if.sv */
interface lsra_cfg_if;
    logic          valid;
    logic          ready;
    lsra_pkg::t_cfg payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/lsra_active_cell.sv */
module lsra_active_cell #(
    parameter int RW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lsra_pkg::t_active_ctl i_ctl,
    input  logic [15:0]           i_new_end,
    input  logic [RW-1:0]         i_new_reg,
    input  logic [31:0]           i_new_val,
    input  logic                  i_prev_valid,
    input  logic                  i_prev_gt,
    input  logic [15:0]           i_prev_end,
    input  logic [RW-1:0]         i_prev_reg,
    input  logic [31:0]           i_prev_val,
    input  logic                  i_next_valid,
    input  logic [15:0]           i_next_end,
    input  logic [RW-1:0]         i_next_reg,
    input  logic [31:0]           i_next_val,
    output logic                  o_valid,
    output logic                  o_gt,
    output logic                  o_tail,
    output logic [15:0]           o_end,
    output logic [RW-1:0]         o_reg,
    output logic [31:0]           o_val
);

    logic          r_valid;
    logic [15:0]   r_end;
    logic [RW-1:0] r_reg;
    logic [31:0]   r_val;

    // This cell lies at or past the insert point when it is empty or ends later.
    assign o_gt    = !r_valid || (r_end > i_new_end);
    assign o_tail  = r_valid && !i_next_valid;
    assign o_valid = r_valid;
    assign o_end   = r_end;
    assign o_reg   = r_reg;
    assign o_val   = r_val;

    // Occupancy: clear, shift toward the head, drop the tail, or open a slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.drop_tail && o_tail) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert && o_gt) begin
            r_valid <= i_prev_gt ? i_prev_valid : 1'b1;
        end
    end

    // Entry contents follow the same moves.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_end <= i_next_end;
            r_reg <= i_next_reg;
            r_val <= i_next_val;
        end else if (i_ctl.insert && o_gt) begin
            if (i_prev_gt) begin
                r_end <= i_prev_end;
                r_reg <= i_prev_reg;
                r_val <= i_prev_val;
            end else begin
                r_end <= i_new_end;
                r_reg <= i_new_reg;
                r_val <= i_new_val;
            end
        end
    end

endmodule

/* sv/lsra_free_cell.sv */
module lsra_free_cell #(
    parameter int RW = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsra_pkg::t_free_ctl i_ctl,
    input  logic [RW-1:0]       i_index,
    input  logic                i_load_valid,
    input  logic                i_prev_valid,
    input  logic [RW-1:0]       i_prev_data,
    input  logic                i_next_valid,
    input  logic [RW-1:0]       i_next_data,
    output logic                o_valid,
    output logic [RW-1:0]       o_data
);

    logic          r_valid;
    logic [RW-1:0] r_data;

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // A push moves every entry one place down, a pop one place up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_load_valid;
        end else if (i_ctl.push) begin
            r_valid <= i_prev_valid;
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_index;
        end else if (i_ctl.push) begin
            r_data <= i_prev_data;
        end else if (i_ctl.pop) begin
            r_data <= i_next_data;
        end
    end

endmodule

/* sv/linear_scan_register_allocator.sv */
// Channel  Port   Dir  Contents
// -------  -----  ---  ---------------------------------------------------
// request  i_req  in   func, value_name, start_pos, end_pos
// result   o_res  out  report_name, kind, register_index, spill_offset, last
// config   i_cfg  in   index (0 register_count, 1 vector_mode), data
//
// A run start is handled in the idle state. An allocate request expires active
// intervals one per cycle through the cell chain, then pops a free register or
// evicts or spills. The active list and free stack are rows of cells.
// Reset (synchronous, active low) empties both rows and clears the spill counter.
// A two-entry result queue lets requests proceed while results wait; the block
// stalls only when the queue lacks room for the results of the current request.
module linear_scan_register_allocator #(
    parameter int NUM_REGS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsra_req_if.sink   i_req,
    lsra_res_if.source o_res,
    lsra_cfg_if.sink   i_cfg
);

    localparam int RW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int RWX = (RW > 5) ? RW : 5;
    localparam int NP  = NUM_REGS + 2;

    function automatic logic [4:0] f_reg5(input logic [RW-1:0] reg_idx);
        logic [RWX-1:0] wide;
        wide = RWX'(reg_idx);
        return wide[4:0];
    endfunction

    // Configuration registers.
    logic [5:0] r_reg_count;
    logic       r_vmode;

    // Control and latched request.
    lsra_pkg::t_state r_state, n_state;
    logic [31:0]   r_name, n_name;
    logic [15:0]   r_start, n_start;
    logic [15:0]   r_end, n_end;
    logic [RW-1:0] r_pend, n_pend;
    logic [15:0]   r_spill, n_spill;
    logic          r_tail_ok, n_tail_ok;
    logic [15:0]   r_tail_end, n_tail_end;
    logic [RW-1:0] r_tail_reg, n_tail_reg;
    logic [31:0]   r_tail_val, n_tail_val;

    // Result queue.
    lsra_pkg::t_res r_q [2];
    lsra_pkg::t_res n_q [2];
    logic [1:0]     r_qcnt, n_qcnt;

    // Chain wiring: position p holds cell p-1, with ties at both ends.
    logic          w_av  [NP];
    logic          w_agt [NP];
    logic [15:0]   w_aend[NP];
    logic [RW-1:0] w_areg[NP];
    logic [31:0]   w_aval[NP];
    logic          w_atail[NUM_REGS];
    logic          w_fv  [NP];
    logic [RW-1:0] w_fd  [NP];

    lsra_pkg::t_active_ctl w_actl;
    lsra_pkg::t_free_ctl   w_fctl;
    logic [RW-1:0]         w_push_data;

    logic           w_push_a, w_push_b;
    lsra_pkg::t_res w_item_a, w_item_b;
    logic           w_take_slot;

    logic           w_sel_ok;
    logic [15:0]    w_sel_end;
    logic [RW-1:0]  w_sel_reg;
    logic [31:0]    w_sel_val;

    logic [16:0]    w_step, w_sum;
    logic [15:0]    w_spill_next;
    logic           w_req_fire, w_res_fire;
    logic           w_room1, w_room2;

    assign w_req_fire  = i_req.valid && i_req.ready;
    assign w_res_fire  = o_res.valid && o_res.ready;
    assign w_room1     = (r_qcnt != 2'd2);
    assign w_room2     = (r_qcnt == 2'd0);
    assign i_req.ready = (r_state == lsra_pkg::S_IDLE) && w_room1;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = (r_qcnt != 2'd0);
    assign o_res.payload = r_q[0];

    // Chain ends.
    assign w_av[0]      = 1'b0;
    assign w_agt[0]     = 1'b0;
    assign w_aend[0]    = '0;
    assign w_areg[0]    = '0;
    assign w_aval[0]    = '0;
    assign w_av[NP-1]   = 1'b0;
    assign w_agt[NP-1]  = 1'b0;
    assign w_aend[NP-1] = '0;
    assign w_areg[NP-1] = '0;
    assign w_aval[NP-1] = '0;
    assign w_fv[0]      = 1'b1;
    assign w_fd[0]      = w_push_data;
    assign w_fv[NP-1]   = 1'b0;
    assign w_fd[NP-1]   = '0;

    // Rows of cells: active list sorted by end, free stack with its top at cell 0.
    for (genvar g = 0; g < NUM_REGS; g++) begin : g_cells
        lsra_active_cell #(.RW(RW)) u_active (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_actl),
            .i_new_end   (r_end),
            .i_new_reg   (r_pend),
            .i_new_val   (r_name),
            .i_prev_valid(w_av[g]),
            .i_prev_gt   (w_agt[g]),
            .i_prev_end  (w_aend[g]),
            .i_prev_reg  (w_areg[g]),
            .i_prev_val  (w_aval[g]),
            .i_next_valid(w_av[g+2]),
            .i_next_end  (w_aend[g+2]),
            .i_next_reg  (w_areg[g+2]),
            .i_next_val  (w_aval[g+2]),
            .o_valid     (w_av[g+1]),
            .o_gt        (w_agt[g+1]),
            .o_tail      (w_atail[g]),
            .o_end       (w_aend[g+1]),
            .o_reg       (w_areg[g+1]),
            .o_val       (w_aval[g+1])
        );

        lsra_free_cell #(.RW(RW)) u_free (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_fctl),
            .i_index     (RW'(g)),
            .i_load_valid(r_reg_count > 6'(g)),
            .i_prev_valid(w_fv[g]),
            .i_prev_data (w_fd[g]),
            .i_next_valid(w_fv[g+2]),
            .i_next_data (w_fd[g+2]),
            .o_valid     (w_fv[g+1]),
            .o_data      (w_fd[g+1])
        );
    end

    // Select the fields of the tail cell; at most one cell flags itself as tail.
    always_comb begin
        w_sel_ok  = 1'b0;
        w_sel_end = '0;
        w_sel_reg = '0;
        w_sel_val = '0;
        for (int k = 0; k < NUM_REGS; k++) begin
            if (w_atail[k]) begin
                w_sel_ok  = 1'b1;
                w_sel_end = w_sel_end | w_aend[k+1];
                w_sel_reg = w_sel_reg | w_areg[k+1];
                w_sel_val = w_sel_val | w_aval[k+1];
            end
        end
    end

    // Saturating spill counter advance.
    assign w_step       = r_vmode ? lsra_pkg::SLOT_VECTOR : lsra_pkg::SLOT_SCALAR;
    assign w_sum        = {1'b0, r_spill} + w_step;
    assign w_spill_next = w_sum[16] ? lsra_pkg::COUNTER_MAX : w_sum[15:0];

    // Sequencer: start a run, or expire, then pop a free register, evict, or spill.
    always_comb begin
        n_state     = r_state;
        n_name      = r_name;
        n_start     = r_start;
        n_end       = r_end;
        n_pend      = r_pend;
        n_tail_ok   = r_tail_ok;
        n_tail_end  = r_tail_end;
        n_tail_reg  = r_tail_reg;
        n_tail_val  = r_tail_val;
        w_actl      = '0;
        w_fctl      = '0;
        w_push_data = w_areg[1];
        w_push_a    = 1'b0;
        w_push_b    = 1'b0;
        w_item_a    = '0;
        w_item_b    = '0;
        w_take_slot = 1'b0;

        case (r_state)
            lsra_pkg::S_IDLE: begin
                if (w_req_fire) begin
                    if (i_req.payload.func == lsra_pkg::FUNC_RUN) begin
                        w_fctl.load          = 1'b1;
                        w_actl.clear         = 1'b1;
                        w_push_a             = 1'b1;
                        w_item_a.kind        = lsra_pkg::KIND_MARK;
                        w_item_a.spill_offset = r_spill;
                        w_item_a.last        = 1'b1;
                    end else begin
                        n_name  = i_req.payload.value_name;
                        n_start = i_req.payload.start_pos;
                        n_end   = i_req.payload.end_pos;
                        n_state = lsra_pkg::S_EXPIRE;
                    end
                end
            end
            lsra_pkg::S_EXPIRE: begin
                n_tail_ok  = w_sel_ok;
                n_tail_end = w_sel_end;
                n_tail_reg = w_sel_reg;
                n_tail_val = w_sel_val;
                if (w_av[1] && (w_aend[1] < r_start)) begin
                    w_actl.shift = 1'b1;
                    w_fctl.push  = !w_fv[NUM_REGS];
                end else if (w_fv[1]) begin
                    if (w_room1) begin
                        w_fctl.pop              = 1'b1;
                        n_pend                  = w_fd[1];
                        w_push_a                = 1'b1;
                        w_item_a.report_name    = r_name;
                        w_item_a.kind           = lsra_pkg::KIND_REG;
                        w_item_a.register_index = f_reg5(w_fd[1]);
                        w_item_a.last           = 1'b1;
                        n_state                 = lsra_pkg::S_INSERT;
                    end
                end else begin
                    n_state = lsra_pkg::S_DECIDE;
                end
            end
            lsra_pkg::S_DECIDE: begin
                if (r_tail_ok && (r_tail_end > r_end)) begin
                    if (w_room2) begin
                        w_actl.drop_tail        = 1'b1;
                        w_take_slot             = 1'b1;
                        n_pend                  = r_tail_reg;
                        w_push_a                = 1'b1;
                        w_item_a.report_name    = r_name;
                        w_item_a.kind           = lsra_pkg::KIND_REG;
                        w_item_a.register_index = f_reg5(r_tail_reg);
                        w_push_b                = 1'b1;
                        w_item_b.report_name    = r_tail_val;
                        w_item_b.kind           = lsra_pkg::KIND_SPILL;
                        w_item_b.spill_offset   = r_spill;
                        w_item_b.last           = 1'b1;
                        n_state                 = lsra_pkg::S_INSERT;
                    end
                end else if (w_room1) begin
                    w_take_slot           = 1'b1;
                    w_push_a              = 1'b1;
                    w_item_a.report_name  = r_name;
                    w_item_a.kind         = lsra_pkg::KIND_SPILL;
                    w_item_a.spill_offset = r_spill;
                    w_item_a.last         = 1'b1;
                    n_state               = lsra_pkg::S_IDLE;
                end
            end
            lsra_pkg::S_INSERT: begin
                w_actl.insert = !w_av[NUM_REGS];
                n_state       = lsra_pkg::S_IDLE;
            end
            default: begin
                n_state = lsra_pkg::S_IDLE;
            end
        endcase
    end

    assign n_spill = w_take_slot ? w_spill_next : r_spill;

    // Result queue: drain the head, then append up to two new results.
    always_comb begin
        n_q    = r_q;
        n_qcnt = r_qcnt;
        if (w_res_fire) begin
            n_q[0] = r_q[1];
            n_qcnt = n_qcnt - 2'd1;
        end
        if (w_push_a) begin
            n_q[n_qcnt[0]] = w_item_a;
            n_qcnt         = n_qcnt + 2'd1;
        end
        if (w_push_b) begin
            n_q[n_qcnt[0]] = w_item_b;
            n_qcnt         = n_qcnt + 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsra_pkg::S_IDLE;
            r_qcnt  <= 2'd0;
            r_spill <= '0;
        end else begin
            r_state <= n_state;
            r_qcnt  <= n_qcnt;
            r_spill <= n_spill;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_name     <= n_name;
        r_start    <= n_start;
        r_end      <= n_end;
        r_pend     <= n_pend;
        r_tail_ok  <= n_tail_ok;
        r_tail_end <= n_tail_end;
        r_tail_reg <= n_tail_reg;
        r_tail_val <= n_tail_val;
        r_q        <= n_q;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count <= lsra_pkg::REG_COUNT_RESET;
            r_vmode     <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.payload.index)
                lsra_pkg::CFG_REG_COUNT:   r_reg_count <= i_cfg.payload.data;
                lsra_pkg::CFG_VECTOR_MODE: r_vmode     <= i_cfg.payload.data[0];
                default: begin
                    r_vmode <= r_vmode;
                end
            endcase
        end
    end

endmodule
